### rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Shared constants, status codes and controller/datapath interface structs
// for the positional list insert and dump unit.
// ----------------------------------------------------------------------------
package plid_pkg;

	localparam int CAPACITY = 32;
	localparam int AW       = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int VAL_W    = 32;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_BAD_POS = 2'd1;
	localparam logic [1:0] STS_FULL    = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch input transfer
		logic check;      // latch error code, init shift index from count
		logic shift_rd;   // read entry idx-1
		logic shift_wr;   // write read data to entry idx, step idx down
		logic place;      // write new value at position, bump count
		logic dump_start; // reset dump index/direction, read entry 0
		logic dump_load;  // load item into output register and advance
		logic stat_load;  // load status-only result into output register
	} plid_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pos_bad;    // position beyond count
		logic full;       // store at capacity
		logic shift_done; // shift index reached the insert position
		logic dump_last;  // current dump item is the final one
		logic out_free;   // output register can take a result this cycle
	} plid_sts_t;

endpackage

### rtl/positional_list_insert_dump_unit.sv
// ----------------------------------------------------------------------------
// positional_list_insert_dump_unit
// Ordered list of signed 32-bit values with insert-at-index and full dump.
// ----------------------------------------------------------------------------
// Each input transfer names a position and a value. A position equal to or
// below the current count inserts the value before that index (zero is the
// front, the count itself appends); the unit then streams the whole list
// front to back (tuser direction 0) and back to front (direction 1), with
// tlast on the final item, so an insert returns twice the new count results.
// A position above the count returns one result with status invalid
// position; a legal position into a full list returns one result with status
// full; both carry zero data, direction 0 and tlast, and leave the list as it
// was. Timing: one input is handled at a time. An insert at position p into n
// entries checks the position, moves the n-p entries from p up one slot in the
// list memory (read, then write; it has one read and one write port), places
// the value and reads the first item; the dump then gives one result per cycle
// while m_tready is high. A result sits in the output register until taken, and
// s_tready rises again as soon as the last result of an item is loaded there.
module positional_list_insert_dump_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] position, [39:8] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] item_value
	output logic [2:0]  m_tuser,   // [0] direction, [2:1] status
	output logic        m_tlast
);
	import plid_pkg::*;

	plid_cmd_t  cmd;
	plid_sts_t  sts;
	logic       out_dir;
	logic [1:0] out_status;

	// sequence the insert and the dump passes
	plid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// list memory, count and the output register
	plid_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_position (s_tdata[POS_W-1:0]),
		.in_value    (s_tdata[POS_W+VAL_W-1:POS_W]),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_item    (m_tdata),
		.out_dir     (out_dir),
		.out_status  (out_status),
		.out_last    (m_tlast)
	);

	// pack the result kind: direction lowest, status above it
	assign m_tuser = {out_status, out_dir};

endmodule

### rtl/plid_dp.sv
// ----------------------------------------------------------------------------
// plid_dp
// Datapath: sequence memory, entry count, shift/dump index and the output
// register that holds a result until the sink takes it.
// ----------------------------------------------------------------------------
module plid_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  plid_pkg::plid_cmd_t               cmd,
	output plid_pkg::plid_sts_t               sts,
	input  logic [plid_pkg::POS_W-1:0]        in_position,
	input  logic [plid_pkg::VAL_W-1:0]        in_value,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [plid_pkg::VAL_W-1:0]        out_item,
	output logic                              out_dir,
	output logic [1:0]                        out_status,
	output logic                              out_last
);
	import plid_pkg::*;

	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] rdata_q;

	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [1:0]       err_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    idx_q;
	logic             dir_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_item_q;
	logic             out_dir_q;
	logic [1:0]       out_status_q;
	logic             out_last_q;

	logic             fwd_end;
	logic [AW-1:0]    nxt_idx;
	logic             nxt_dir;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;

	assign fwd_end = (CW'(idx_q) + CW'(1)) == cnt_q;

	always_comb begin
		nxt_idx = idx_q;
		nxt_dir = dir_q;
		if (!dir_q && fwd_end) begin
			nxt_dir = 1'b1;
		end else if (!dir_q) begin
			nxt_idx = idx_q + AW'(1);
		end else begin
			nxt_idx = idx_q - AW'(1);
		end
	end

	assign sts.pos_bad    = pos_q > POS_W'(cnt_q);
	assign sts.full       = cnt_q == CW'(CAPACITY);
	assign sts.shift_done = idx_q == pos_q[AW-1:0];
	assign sts.dump_last  = dir_q && (idx_q == '0);
	assign sts.out_free   = !out_valid_q || out_ready;

	// single read port
	always_comb begin
		rd_en   = cmd.shift_rd || cmd.dump_start || (cmd.dump_load && !sts.dump_last);
		rd_addr = nxt_idx;
		if (cmd.shift_rd) begin
			rd_addr = idx_q - AW'(1);
		end else if (cmd.dump_start) begin
			rd_addr = '0;
		end
	end

	// single write port
	always_comb begin
		wr_en   = cmd.shift_wr || cmd.place;
		wr_addr = idx_q;
		wr_data = rdata_q;
		if (cmd.place) begin
			wr_addr = pos_q[AW-1:0];
			wr_data = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q <= in_position;
			val_q <= in_value;
		end
		if (cmd.check) begin
			err_q <= sts.pos_bad ? STS_BAD_POS : STS_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			dir_q <= 1'b0;
		end else begin
			if (cmd.check) begin
				idx_q <= cnt_q[AW-1:0];
			end
			if (cmd.shift_wr) begin
				idx_q <= idx_q - AW'(1);
			end
			if (cmd.place) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.dump_start) begin
				idx_q <= '0;
				dir_q <= 1'b0;
			end
			if (cmd.dump_load) begin
				idx_q <= nxt_idx;
				dir_q <= nxt_dir;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.dump_load || cmd.stat_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dump_load) begin
			out_item_q   <= rdata_q;
			out_dir_q    <= dir_q;
			out_status_q <= STS_OK;
			out_last_q   <= sts.dump_last;
		end else if (cmd.stat_load) begin
			out_item_q   <= '0;
			out_dir_q    <= 1'b0;
			out_status_q <= err_q;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_item   = out_item_q;
	assign out_dir    = out_dir_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_only_on_place: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.place |=> cnt_q == $past(cnt_q))
		else $error("entry count moved without an insert");

	a_ok_last_backward: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q && out_status_q == STS_OK |-> out_dir_q)
		else $error("dump ended outside the backward pass");

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dump_load || cmd.stat_load) |-> sts.out_free)
		else $error("output register overwritten before transfer");

endmodule

### rtl/plid_ctrl.sv
// ----------------------------------------------------------------------------
// plid_ctrl
// Controller: check, tail shift, placement, two dump passes or status result.
// ----------------------------------------------------------------------------
module plid_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  plid_pkg::plid_sts_t sts,
	output plid_pkg::plid_cmd_t cmd
);
	import plid_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_SRD   = 8'b0000_0100,
		S_SWR   = 8'b0000_1000,
		S_PLACE = 8'b0001_0000,
		S_DRD   = 8'b0010_0000,
		S_DLD   = 8'b0100_0000,
		S_STAT  = 8'b1000_0000
	} plid_state_t;

	plid_state_t state_q, state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.pos_bad || sts.full) begin
					state_d = S_STAT;
				end else begin
					state_d = S_SRD;
				end
			end
			S_SRD: begin
				if (sts.shift_done) begin
					state_d = S_PLACE;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d      = S_SWR;
				end
			end
			S_SWR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_SRD;
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_DRD;
			end
			S_DRD: begin
				cmd.dump_start = 1'b1;
				state_d        = S_DLD;
			end
			S_DLD: begin
				if (sts.out_free) begin
					cmd.dump_load = 1'b1;
					if (sts.dump_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_STAT: begin
				if (sts.out_free) begin
					cmd.stat_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_shift_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWR |-> $past(state_q) == S_SRD)
		else $error("shift write without a preceding read");

	a_place_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLACE |-> $past(state_q) == S_SRD && $past(sts.shift_done))
		else $error("value placed before the tail was shifted");

	a_dump_after_place: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |=> state_q == S_DRD)
		else $error("dump did not follow the insert");

endmodule
